// ===== rtl/thfam_pkg.sv =====
// Shared constants and functions for the tilt and heading pipeline.
// Holds the arctangent step table and the angle rounding helper.
// No dependencies.
package thfam_pkg;

  localparam int AngleIterationsDef = 16;
  localparam int AtanTableSize      = 24;
  localparam int CordicW            = 30;
  localparam int AngleW             = 26;
  localparam int QuarterTurnAcc     = 9000 * 1024;
  localparam int HalfTurn           = 18000;

  function automatic logic [AngleW-1:0] atan_step(input logic [4:0] idx);
    logic [AngleW-1:0] v;
    unique case (idx)
      5'd0:  v = 26'd4608000;
      5'd1:  v = 26'd2720261;
      5'd2:  v = 26'd1437311;
      5'd3:  v = 26'd729602;
      5'd4:  v = 26'd366217;
      5'd5:  v = 26'd183287;
      5'd6:  v = 26'd91666;
      5'd7:  v = 26'd45836;
      5'd8:  v = 26'd22918;
      5'd9:  v = 26'd11459;
      5'd10: v = 26'd5730;
      5'd11: v = 26'd2865;
      5'd12: v = 26'd1432;
      5'd13: v = 26'd716;
      5'd14: v = 26'd358;
      5'd15: v = 26'd179;
      5'd16: v = 26'd90;
      5'd17: v = 26'd45;
      5'd18: v = 26'd22;
      5'd19: v = 26'd11;
      5'd20: v = 26'd6;
      5'd21: v = 26'd3;
      5'd22: v = 26'd1;
      5'd23: v = 26'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] round_angle(input logic signed [AngleW-1:0] z);
    logic [AngleW-1:0] mag;
    logic [AngleW-1:0] res;
    logic [15:0]       cl;
    mag = z[AngleW-1] ? AngleW'(-z) : z;
    res = (mag + AngleW'(512)) >> 10;
    cl  = (res > AngleW'(HalfTurn)) ? 16'(HalfTurn) : res[15:0];
    return z[AngleW-1] ? -$signed(cl) : $signed(cl);
  endfunction

endpackage

// ===== rtl/tilt_heading_from_accel_mag.sv =====
// Tilt and heading pipeline: roll, pitch, heading and gyro norm per sample.
// Results pass through one input stage, 25 square-root stages and N + 2 CORDIC
// stages, N being ANGLE_ITERATIONS capped at 24.
// Throughput is one request per cycle; start is never refused and busy stays low.
// Reset clears only the valid chain; data registers are not reset.
module tilt_heading_from_accel_mag import thfam_pkg::*; #(
  parameter int ANGLE_ITERATIONS = AngleIterationsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] rate_x_i,
  input  logic signed [15:0] rate_y_i,
  input  logic signed [15:0] rate_z_i,
  input  logic signed [15:0] field_x_i,
  input  logic signed [15:0] field_y_i,
  output logic               done_o,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] heading_angle_o,
  output logic [15:0]        rate_magnitude_o
);
  localparam int N      = (ANGLE_ITERATIONS > AtanTableSize) ? AtanTableSize
                                                             : ANGLE_ITERATIONS;
  localparam int SqLat  = 25;
  localparam int CorLat = N + 2;
  localparam int Total  = 1 + SqLat + CorLat;

  assign busy = 1'b0;

  logic signed [15:0] ax_q, ay_q, az_q, mx_q, my_q;
  logic [32:0]        hsq_q;
  logic [33:0]        gsq_q;
  always_ff @(posedge clk_i) begin
    ax_q  <= accel_x_i;
    ay_q  <= accel_y_i;
    az_q  <= accel_z_i;
    mx_q  <= field_x_i;
    my_q  <= field_y_i;
    hsq_q <= 33'($signed(accel_y_i) * $signed(accel_y_i))
           + 33'($signed(accel_z_i) * $signed(accel_z_i));
    gsq_q <= 34'($signed(rate_x_i) * $signed(rate_x_i))
           + 34'($signed(rate_y_i) * $signed(rate_y_i))
           + 34'($signed(rate_z_i) * $signed(rate_z_i));
  end

  logic [24:0] hyp;
  thfam_isqrt #(.RadW(49), .Round(0), .Lat(SqLat)) u_hyp (
    .clk_i, .rad_i({hsq_q, 16'd0}), .root_o(hyp));

  logic [17:0] gr;
  thfam_isqrt #(.RadW(34), .Round(1), .Lat(SqLat)) u_gyr (
    .clk_i, .rad_i(gsq_q), .root_o(gr));

  logic signed [15:0] ax_d [0:SqLat], ay_d [0:SqLat], az_d [0:SqLat];
  logic signed [15:0] mx_d [0:SqLat], my_d [0:SqLat];
  assign ax_d[0] = ax_q;
  assign ay_d[0] = ay_q;
  assign az_d[0] = az_q;
  assign mx_d[0] = mx_q;
  assign my_d[0] = my_q;
  for (genvar k = 0; k < SqLat; k++) begin : g_dl
    always_ff @(posedge clk_i) begin
      ax_d[k+1] <= ax_d[k];
      ay_d[k+1] <= ay_d[k];
      az_d[k+1] <= az_d[k];
      mx_d[k+1] <= mx_d[k];
      my_d[k+1] <= my_d[k];
    end
  end

  logic signed [15:0] roll, pitch, head;
  thfam_cordic #(.Iters(ANGLE_ITERATIONS)) u_roll (
    .clk_i, .y_i(CordicW'(ay_d[SqLat]) <<< 8), .x_i(CordicW'(az_d[SqLat]) <<< 8),
    .angle_o(roll));
  thfam_cordic #(.Iters(ANGLE_ITERATIONS)) u_pitch (
    .clk_i, .y_i(-(CordicW'(ax_d[SqLat]) <<< 8)),
    .x_i($signed(CordicW'(hyp))), .angle_o(pitch));
  thfam_cordic #(.Iters(ANGLE_ITERATIONS)) u_head (
    .clk_i, .y_i(CordicW'(my_d[SqLat]) <<< 8), .x_i(CordicW'(mx_d[SqLat]) <<< 8),
    .angle_o(head));

  logic [15:0] gmag_d [0:CorLat];
  assign gmag_d[0] = (gr > 18'hFFFF) ? 16'hFFFF : gr[15:0];
  for (genvar k = 0; k < CorLat; k++) begin : g_gm
    always_ff @(posedge clk_i) gmag_d[k+1] <= gmag_d[k];
  end

  logic [Total-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Total-2:0], start};
    end
  end

  assign done_o           = vld_q[Total-1];
  assign roll_angle_o     = roll;
  assign pitch_angle_o    = pitch;
  assign heading_angle_o  = head;
  assign rate_magnitude_o = gmag_d[CorLat];

  a_no_busy: assert property (@(posedge clk_i) busy == 1'b0)
    else $error("busy raised");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, Total)) else $error("done without request");
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (roll_angle_o <= 16'sd18000 && roll_angle_o >= -16'sd18000))
    else $error("roll out of range");
endmodule

// ===== rtl/thfam_isqrt.sv =====
// Pipelined restoring square root, one result bit per stage.
// Gives floor(sqrt(rad_i)) and optionally rounds to nearest. Uses thfam_pkg.
module thfam_isqrt import thfam_pkg::*; #(
  parameter int RadW  = 34,
  parameter int Round = 0,
  parameter int Lat   = 18
) (
  input  logic              clk_i,
  input  logic [RadW-1:0]   rad_i,
  output logic [RadW/2:0]   root_o
);
  localparam int RootW = RadW / 2;
  localparam int Pad   = Lat - RootW - 1;

  logic [RadW-1:0]  rem_q  [0:RootW];
  logic [RootW-1:0] root_q [0:RootW];

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= rad_i;
    root_q[0] <= '0;
  end

  for (genvar s = 0; s < RootW; s++) begin : g_st
    localparam int B = RootW - 1 - s;
    logic [RadW+1:0] trial;
    always_comb begin
      trial = ((RadW+2)'(root_q[s]) << (B + 1)) | ((RadW+2)'(1) << (2 * B));
    end
    always_ff @(posedge clk_i) begin
      if ((RadW+2)'(rem_q[s]) >= trial) begin
        rem_q[s+1]  <= RadW'((RadW+2)'(rem_q[s]) - trial);
        root_q[s+1] <= root_q[s] | (RootW'(1) << B);
      end else begin
        rem_q[s+1]  <= rem_q[s];
        root_q[s+1] <= root_q[s];
      end
    end
  end

  logic [RootW:0] rnd;
  always_comb begin
    rnd = (RootW+1)'(root_q[RootW]);
    if (Round != 0 && (rem_q[RootW] > RadW'(root_q[RootW])))
      rnd = rnd + 1'b1;
  end

  logic [RootW:0] out_q [0:Pad];
  assign out_q[0] = rnd;
  for (genvar k = 0; k < Pad; k++) begin : g_pad
    always_ff @(posedge clk_i) out_q[k+1] <= out_q[k];
  end
  assign root_o = out_q[Pad];
endmodule

// ===== rtl/thfam_cordic.sv =====
// Pipelined vectoring CORDIC, one micro-rotation per register stage.
// Turns (y, x) into atan2 in hundredths of a degree. Uses thfam_pkg.
module thfam_cordic import thfam_pkg::*; #(
  parameter int Iters = AngleIterationsDef
) (
  input  logic                        clk_i,
  input  logic signed [CordicW-1:0]   y_i,
  input  logic signed [CordicW-1:0]   x_i,
  output logic signed [15:0]          angle_o
);
  localparam int N = (Iters > AtanTableSize) ? AtanTableSize : Iters;

  logic signed [CordicW+1:0] x_q [0:N];
  logic signed [CordicW+1:0] y_q [0:N];
  logic signed [AngleW-1:0]  z_q [0:N];
  logic                      zero_q [0:N];
  logic signed [15:0]        ang_q;

  always_ff @(posedge clk_i) begin
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x_q[0] <= (CordicW+2)'(y_i);
        y_q[0] <= -(CordicW+2)'(x_i);
        z_q[0] <= AngleW'(QuarterTurnAcc);
      end else begin
        x_q[0] <= -(CordicW+2)'(y_i);
        y_q[0] <= (CordicW+2)'(x_i);
        z_q[0] <= -AngleW'(QuarterTurnAcc);
      end
    end else begin
      x_q[0] <= (CordicW+2)'(x_i);
      y_q[0] <= (CordicW+2)'(y_i);
      z_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    always_ff @(posedge clk_i) begin
      zero_q[i+1] <= zero_q[i];
      if (y_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + $signed(atan_step(5'(i)));
      end else begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - $signed(atan_step(5'(i)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q <= zero_q[N] ? '0 : round_angle(z_q[N]);
  end
  assign angle_o = ang_q;
endmodule

// ===== bench/tilt_heading_from_accel_mag_tb.sv =====
// Self-checking testbench for the tilt and heading pipeline.
// A scoreboard class predicts roll, pitch, heading and gyro norm per request.
// Depends on thfam_pkg and tilt_heading_from_accel_mag.
`timescale 1ns / 100ps

module tilt_heading_from_accel_mag_tb;
  import thfam_pkg::*;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] heading;
    logic [15:0]        rate_mag;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] ax, ay, az, rx, ry, rz, mx, my;
  } sample_t;

  class angle_scoreboard;
    angles_t expected_angles[$];
    int      mismatches = 0;

    function automatic longint floor_shr(longint v, int n);
      return v >>> n;
    endfunction

    function automatic longint int_sqrt(longint unsigned s);
      longint unsigned root = 0;
      longint unsigned bit_w = 64'd1 << 62;
      while (bit_w > s) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
        if (s >= root + bit_w) begin
          s = s - (root + bit_w);
          root = (root >> 1) + bit_w;
        end else begin
          root = root >> 1;
        end
        bit_w = bit_w >> 2;
      end
      return longint'(root);
    endfunction

    function automatic logic signed [15:0] vector_angle(longint y, longint x);
      longint z = 0;
      longint t, dx, dy, mag, res;
      int iters;
      iters = (AngleIterationsDef > AtanTableSize) ? AtanTableSize : AngleIterationsDef;
      if (x == 0 && y == 0) return 16'sd0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = QuarterTurnAcc;
        end else begin
          x = -y; y = t; z = -QuarterTurnAcc;
        end
      end
      for (int i = 0; i < iters; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        t = longint'(atan_step(5'(i)));
        if (y >= 0) begin
          x += dx; y -= dy; z += t;
        end else begin
          x -= dx; y += dy; z -= t;
        end
      end
      mag = (z < 0) ? -z : z;
      res = (mag + 512) / 1024;
      if (res > HalfTurn) res = HalfTurn;
      if (z < 0) res = -res;
      return 16'(res);
    endfunction

    function void note_request(sample_t s);
      angles_t e;
      longint ax, ay, az, rx, ry, rz, mx, my, hyp, gs, gr;
      ax = s.ax; ay = s.ay; az = s.az; rx = s.rx; ry = s.ry; rz = s.rz;
      mx = s.mx; my = s.my;
      e.roll = vector_angle(ay * 256, az * 256);
      hyp = int_sqrt(longint'((ay * ay + az * az) << 16));
      e.pitch = vector_angle(-ax * 256, hyp);
      e.heading = vector_angle(my * 256, mx * 256);
      gs = rx * rx + ry * ry + rz * rz;
      gr = int_sqrt(gs);
      if (gs - gr * gr > gr) gr++;
      if (gr > 65535) gr = 65535;
      e.rate_mag = 16'(gr);
      expected_angles.push_back(e);
    endfunction

    task report(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      mismatches++;
    endtask

    task check_result(angles_t r);
      angles_t e;
      if (expected_angles.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      e = expected_angles.pop_front();
      if (r.roll !== e.roll) report("roll", r.roll, e.roll);
      if (r.pitch !== e.pitch) report("pitch", r.pitch, e.pitch);
      if (r.heading !== e.heading) report("heading", r.heading, e.heading);
      if (r.rate_mag !== e.rate_mag) report("rate_magnitude", r.rate_mag, e.rate_mag);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy, done;
  sample_t smp = '0;
  logic signed [15:0] roll_o, pitch_o, heading_o;
  logic [15:0] rate_mag_o;
  longint cycle_count = 0;
  angle_scoreboard sb = new();

  tilt_heading_from_accel_mag i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .accel_x_i(smp.ax), .accel_y_i(smp.ay), .accel_z_i(smp.az),
    .rate_x_i(smp.rx), .rate_y_i(smp.ry), .rate_z_i(smp.rz),
    .field_x_i(smp.mx), .field_y_i(smp.my),
    .done_o(done),
    .roll_angle_o(roll_o), .pitch_angle_o(pitch_o),
    .heading_angle_o(heading_o), .rate_magnitude_o(rate_mag_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("tilt_heading_from_accel_mag_tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done) sb.check_result({roll_o, pitch_o, heading_o, rate_mag_o});
  end

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task send_request(sample_t s, bit may_idle);
    if (may_idle && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start <= 1'b1;
    smp <= s;
    do @(posedge clk_i); while (busy);
    sb.note_request(s);
  endtask

  initial begin
    sample_t directed[$];
    sample_t s;
    directed.push_back('0);
    directed.push_back({8{16'h7FFF}});
    directed.push_back({8{16'h8000}});
    directed.push_back({16'h0000, 16'h0000, 16'h8000, 48'h0, 16'h8000, 16'h0000});
    directed.push_back({16'h7FFF, 16'h0000, 16'h0000, 48'h0, 16'h0000, 16'h7FFF});
    directed.push_back({16'h8000, 16'h8000, 16'h8000, 48'h0, 16'h8000, 16'h8000});
    directed.push_back({16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001, 16'h0001,
                        16'hFFFF, 16'h0001});
    directed.push_back({16'h0000, 16'h0005, 16'h0000, 16'h8000, 16'h8000, 16'h8000,
                        16'h0000, 16'hFFFB});
    directed.push_back({16'hFFF6, 16'hFFF6, 16'hFFEC, 16'h0003, 16'h0004, 16'h0000,
                        16'hFFEC, 16'h000A});
    directed.push_back({16'h1234, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
                        16'h7FFF, 16'h8000});
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_request(directed[i], 1'b0);
    for (int n = 0; n < 550; n++) begin
      s = {pick_field(), pick_field(), pick_field(), pick_field(),
           pick_field(), pick_field(), pick_field(), pick_field()};
      send_request(s, !(n >= 200 && n < 350));
    end
    start <= 1'b0;
    while (sb.expected_angles.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("tilt_heading_from_accel_mag_tb passed");
    end else begin
      $display("tilt_heading_from_accel_mag_tb failed");
    end
    $finish;
  end

endmodule
